/* rtl/stot_pkg.sv */
// Package for the section table offset translator.
// Beat types, item kind and status codes, config indexes, FSM state and the
// command/status structs between controller and datapath. No dependencies.
package stot_pkg;

    localparam int unsigned MAX_SECTIONS_DEF = 16;

    // Item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_F2V  = 2'd1;
    localparam logic [1:0] KIND_V2F  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_HEADER  = 2'd0;
    localparam logic [1:0] ST_SECTION = 2'd1;
    localparam logic [1:0] ST_OUT     = 2'd2;
    localparam logic [1:0] ST_LOADED  = 2'd3;

    // Config register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIRT_ALIGN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_LEN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd2;

    localparam logic [31:0] VIRT_ALIGN_RST = 32'd4096;
    localparam logic [31:0] HDR_LEN_RST    = 32'd1024;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] query_offset;
        logic [3:0]  entry_index;
        logic [31:0] entry_virt_start;
        logic [31:0] entry_virt_size;
        logic [31:0] entry_file_start;
        logic [31:0] entry_file_size;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] mapped_offset;
        logic [31:0] block_size;
        logic [3:0]  hit_section;
    } out_beat_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [31:0] vstart;
        logic [31:0] vsize;
        logic [31:0] fstart;
        logic [31:0] fsize;
    } sect_t;

    localparam int unsigned SECT_W = $bits(sect_t);

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_SCAN,
        CTL_DRAIN,
        CTL_FIN1,
        CTL_FIN2,
        CTL_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic capture;    // take the input beat, clear scan state
        logic scan_step;  // read next entry, advance scan counter
        logic fin1;       // first finishing stage
        logic fin2;       // second finishing stage
        logic out_load;   // move result into the output register
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] in_kind;
        logic       scan_empty;
        logic       scan_last;
        logic       out_free;
    } dp_stat_t;

endpackage

/* rtl/stot_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stot_ram #(
    parameter int unsigned WIDTH  = 128,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/stot_ctrl.sv */
// Sequencing FSM for the section table offset translator.
// Depends on stot_pkg (state enum, kind codes, command/status structs).
module stot_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stot_pkg::dp_stat_t  stat,
    output stot_pkg::ctl_cmd_t  cmd
);

    stot_pkg::ctl_state_t state_reg, state_next;

    logic is_query;
    assign is_query = (stat.in_kind == stot_pkg::KIND_F2V) ||
                      (stat.in_kind == stot_pkg::KIND_V2F);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stot_pkg::CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stot_pkg::CTL_IDLE: begin
                if (s_valid) begin
                    if (!is_query) state_next = stot_pkg::CTL_EMIT;
                    else if (stat.scan_empty) state_next = stot_pkg::CTL_FIN1;
                    else state_next = stot_pkg::CTL_SCAN;
                end
            end
            stot_pkg::CTL_SCAN: begin
                if (stat.scan_last) state_next = stot_pkg::CTL_DRAIN;
            end
            stot_pkg::CTL_DRAIN: state_next = stot_pkg::CTL_FIN1;
            stot_pkg::CTL_FIN1:  state_next = stot_pkg::CTL_FIN2;
            stot_pkg::CTL_FIN2:  state_next = stot_pkg::CTL_EMIT;
            stot_pkg::CTL_EMIT: begin
                if (stat.out_free) state_next = stot_pkg::CTL_IDLE;
            end
            default: state_next = stot_pkg::CTL_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            stot_pkg::CTL_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            stot_pkg::CTL_SCAN:  cmd.scan_step = 1'b1;
            stot_pkg::CTL_DRAIN: ;
            stot_pkg::CTL_FIN1:  cmd.fin1 = 1'b1;
            stot_pkg::CTL_FIN2:  cmd.fin2 = 1'b1;
            stot_pkg::CTL_EMIT:  cmd.out_load = stat.out_free;
            default: ;
        endcase
    end

endmodule

/* rtl/stot_dp.sv */
// Datapath of the section table offset translator: config registers, table
// RAM, scan evaluation, finishing stages and output register.
// Depends on stot_pkg and stot_ram.
module stot_dp #(
    parameter int unsigned MAX_SECTIONS = stot_pkg::MAX_SECTIONS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  stot_pkg::in_beat_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output stot_pkg::out_beat_t                m_data,
    input  logic                               cfg_we,
    input  logic [stot_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_wdata,
    input  stot_pkg::ctl_cmd_t                 cmd,
    output stot_pkg::dp_stat_t                 stat
);

    localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1);

    // Config
    logic [31:0] virt_align_reg, hdr_len_reg;
    logic [4:0]  section_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            virt_align_reg    <= stot_pkg::VIRT_ALIGN_RST;
            hdr_len_reg       <= stot_pkg::HDR_LEN_RST;
            section_count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                stot_pkg::CFG_VIRT_ALIGN:    virt_align_reg    <= cfg_wdata;
                stot_pkg::CFG_HDR_LEN:       hdr_len_reg       <= cfg_wdata;
                stot_pkg::CFG_SECTION_COUNT: section_count_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] n_live;
    assign n_live = (32'(section_count_reg) > 32'(MAX_SECTIONS)) ?
                    CNT_W'(MAX_SECTIONS) : CNT_W'(section_count_reg);

    // Accepted item
    logic [1:0]  kind_reg;
    logic [31:0] q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_data.kind;
            q_reg    <= s_data.query_offset;
        end
    end

    // Table RAM
    logic             ram_we;
    stot_pkg::sect_t  ram_wdata, ent;
    logic [stot_pkg::SECT_W-1:0] ram_rdata;
    logic [CNT_W-1:0] scan_cnt_reg;

    assign ram_we = cmd.capture && (s_data.kind == stot_pkg::KIND_LOAD) &&
                    (32'(s_data.entry_index) < 32'(MAX_SECTIONS));
    assign ram_wdata = '{vstart: s_data.entry_virt_start,
                         vsize:  s_data.entry_virt_size,
                         fstart: s_data.entry_file_start,
                         fsize:  s_data.entry_file_size};

    stot_ram #(
        .WIDTH (stot_pkg::SECT_W),
        .DEPTH (MAX_SECTIONS),
        .ADDR_W(IDX_W)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(IDX_W'(s_data.entry_index)),
        .wdata(ram_wdata),
        .re   (cmd.scan_step),
        .raddr(scan_cnt_reg[IDX_W-1:0]),
        .rdata(ram_rdata)
    );
    assign ent = ram_rdata;

    // Scan
    logic             eval_reg;
    logic [IDX_W-1:0] eidx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_reg     <= 1'b0;
            scan_cnt_reg <= '0;
        end else begin
            eval_reg <= cmd.scan_step;
            if (cmd.capture) scan_cnt_reg <= '0;
            else if (cmd.scan_step) scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        eidx_reg <= scan_cnt_reg[IDX_W-1:0];
    end

    logic [31:0]      f_end, v_end;
    logic             hit_f, hit_v, hit;
    logic [31:0]      peak_reg;
    logic             found_reg, lock_reg;
    stot_pkg::sect_t  cand_reg;
    logic [IDX_W-1:0] cidx_reg;

    assign f_end = ent.fstart + ent.fsize;
    assign v_end = ent.vstart + ent.vsize;
    assign hit_f = (ent.fsize != '0) && (ent.fstart <= q_reg) && (f_end > q_reg);
    assign hit_v = (ent.vstart <= q_reg) && (v_end > q_reg);
    assign hit   = (kind_reg == stot_pkg::KIND_F2V) ? hit_f : hit_v;

    // File lookups freeze on the first hit; virtual lookups freeze on the
    // first hit with file data, else keep the last one without.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            peak_reg  <= '0;
            found_reg <= 1'b0;
            lock_reg  <= 1'b0;
        end else if (eval_reg) begin
            if ((kind_reg == stot_pkg::KIND_F2V) && (f_end > peak_reg)) peak_reg <= f_end;
            if (hit && !lock_reg) begin
                found_reg <= 1'b1;
                lock_reg  <= (kind_reg == stot_pkg::KIND_F2V) || (ent.fsize != '0);
                cand_reg  <= ent;
                cidx_reg  <= eidx_reg;
            end
        end
    end

    // Finishing stage 1
    logic [31:0] align_mask;
    logic [31:0] off_reg, aux_reg, hdr_blk_reg;
    logic        ge_peak_reg, lt_hdr_reg, lt_align_reg;

    assign align_mask = virt_align_reg - 32'd1;

    always_ff @(posedge aclk) begin
        if (cmd.fin1) begin
            ge_peak_reg  <= q_reg >= peak_reg;
            lt_hdr_reg   <= q_reg < hdr_len_reg;
            lt_align_reg <= q_reg < virt_align_reg;
            if (kind_reg == stot_pkg::KIND_F2V) begin
                off_reg     <= q_reg - cand_reg.fstart;
                aux_reg     <= (cand_reg.vsize + align_mask) & ~align_mask;  // aligned size
                hdr_blk_reg <= virt_align_reg - q_reg;
            end else begin
                off_reg     <= q_reg - cand_reg.vstart;
                aux_reg     <= cand_reg.fstart + cand_reg.fsize;             // file end
                hdr_blk_reg <= hdr_len_reg - q_reg;
            end
        end
    end

    // Finishing stage 2
    logic [31:0] map_reg, lim_reg, sblk_reg;

    always_ff @(posedge aclk) begin
        if (cmd.fin2) begin
            lim_reg  <= cand_reg.vstart + aux_reg;
            sblk_reg <= aux_reg - off_reg;
            if (kind_reg == stot_pkg::KIND_F2V) map_reg <= off_reg + cand_reg.vstart;
            else map_reg <= off_reg + cand_reg.fstart;
        end
    end

    // Result selection
    stot_pkg::out_beat_t res, sec_res, hdr_res;

    always_comb begin
        sec_res = '{status: stot_pkg::ST_SECTION, mapped_offset: map_reg,
                    block_size: sblk_reg, hit_section: 4'(cidx_reg)};
        hdr_res = '{status: stot_pkg::ST_HEADER, mapped_offset: q_reg,
                    block_size: hdr_blk_reg, hit_section: 4'd0};
        res     = '0;
        res.status = stot_pkg::ST_OUT;
        case (kind_reg)
            stot_pkg::KIND_LOAD: res.status = stot_pkg::ST_LOADED;
            stot_pkg::KIND_F2V: begin
                if (ge_peak_reg) ;
                else if (lt_hdr_reg) res = hdr_res;
                else if (found_reg && !(map_reg > lim_reg)) res = sec_res;
            end
            stot_pkg::KIND_V2F: begin
                if (lt_align_reg) begin
                    if (lt_hdr_reg) res = hdr_res;
                end else if (found_reg && (map_reg < aux_reg)) begin
                    res = sec_res;
                    res.block_size = aux_reg - map_reg;
                end
            end
            default: ;
        endcase
    end

    // Output register
    logic                m_valid_reg, m_valid_next;
    stot_pkg::out_beat_t m_data_reg;

    assign m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_data_reg <= res;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.in_kind    = s_data.kind;
    assign stat.scan_empty = (n_live == '0);
    assign stat.scan_last  = (CNT_W'(scan_cnt_reg + 1'b1) == n_live);
    assign stat.out_free   = !m_valid_reg || m_ready;

    // Checks
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an unconsumed beat");

    a_scan_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (32'(scan_cnt_reg) < 32'(n_live)))
        else $error("scan past live section count");

    a_scan_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> !stat.scan_empty)
        else $error("scan started with empty table");

    a_load_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && (kind_reg == stot_pkg::KIND_LOAD))
        |=> (m_data_reg.status == stot_pkg::ST_LOADED))
        else $error("load beat without loaded status");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status != stot_pkg::ST_SECTION))
        |-> (m_data_reg.hit_section == 4'd0))
        else $error("section index set on a non-section result");

endmodule

/* rtl/section_table_offset_translator.sv */
// Section table offset translator, top level.
// Input beats (s_valid/s_ready/s_data) carry a section entry load or a query:
//  file offset to virtual offset, or virtual offset to file offset.
// Each input beat gives one result beat on m_valid/m_ready/m_data: status,
//  mapped offset, bytes left in the mapped block and matched section index.
// cfg_we/cfg_index/cfg_wdata write virt_align, header length and
//  section_count; write them only while the block is idle.
// Flow: loads and unused kinds go from capture straight to result hand-over.
//  Queries scan the table RAM (one registered read port) one entry per cycle
//  over the N live entries, N = min(section_count, MAX_SECTIONS), then pass
//  DRAIN, FIN1 and FIN2 before hand-over (no scan and no DRAIN when N is 0).
//  A new beat is taken only once the previous result has been handed over.
// Reset: synchronous, active low. Config returns to virt_align 4096, header
//  length 1024, section_count 0; the table is undefined until loaded, so
//  load every entry a query can reach.
// Stalls: the result beat waits in an output register while s_ready stays
//  high; the next beat is taken and worked on, holding only at its own
//  result hand-over until m_ready frees the register.
module section_table_offset_translator #(
    parameter int unsigned MAX_SECTIONS = stot_pkg::MAX_SECTIONS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_valid,
    output logic                            s_ready,
    input  stot_pkg::in_beat_t              s_data,
    // result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output stot_pkg::out_beat_t             m_data,
    // config write port
    input  logic                            cfg_we,
    input  logic [stot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_wdata
);

    stot_pkg::ctl_cmd_t cmd;
    stot_pkg::dp_stat_t stat;

    // Controller: sequences capture, table scan, two finishing stages and
    // result hand-over.
    stot_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    // Datapath: config, section table RAM, per-entry compare and
    // result register.
    stot_dp #(
        .MAX_SECTIONS(MAX_SECTIONS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

/* verif/section_table_offset_translator_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for section_table_offset_translator: a queue-fed driver
// offers beats, a monitor checks every result beat against a local predictor.
// Depends on stot_pkg and the translator RTL only.
module section_table_offset_translator_test;

    localparam int CLK_PERIOD       = 12;
    localparam int TABLE_DEPTH      = stot_pkg::MAX_SECTIONS_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int PHASES           = 8;
    localparam int PHASE_BEATS      = 190;
    localparam int LONG_HOLD_AT     = 600;   // result count that starts the long back-pressure
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 24;    // > slowest query over a full table, plus margin
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [31:0] vstart;
        logic [31:0] vsize;
        logic [31:0] fstart;
        logic [31:0] fsize;
    } image_section_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    stot_pkg::in_beat_t             s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    stot_pkg::out_beat_t            m_data;
    logic                           cfg_we    = 1'b0;
    logic [stot_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                    cfg_wdata = '0;

    section_table_offset_translator #(
        .MAX_SECTIONS (TABLE_DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: own copy of the section table and the registers
    // ------------------------------------------------------------------
    image_section_t section_image [TABLE_DEPTH];
    logic [31:0]    align_now  = stot_pkg::VIRT_ALIGN_RST;
    logic [31:0]    header_now = stot_pkg::HDR_LEN_RST;
    logic [4:0]     count_now  = '0;

    stot_pkg::in_beat_t  beat_backlog[$];      // beats waiting for the driver
    stot_pkg::out_beat_t awaited_answers[$];   // predicted results, oldest first

    int fault_count    = 0;
    int answers_seen   = 0;
    int send_gap       = 0;
    int hold_left      = 0;
    bit tx_calm        = 1'b0;
    bit rx_calm        = 1'b0;
    bit long_hold_done = 1'b0;

    // Works out the result of one accepted beat and applies its side effect
    // (a load writes the local table).
    function automatic stot_pkg::out_beat_t translate_beat(stot_pkg::in_beat_t b);
        stot_pkg::out_beat_t r;
        image_section_t      e;
        logic [31:0]         q, peak, fend, off, mapped, mask, asz;
        int                  live, j, pick;
        bit                  found, settled;
        r        = '0;
        r.status = stot_pkg::ST_OUT;
        q        = b.query_offset;
        live     = (count_now > TABLE_DEPTH) ? TABLE_DEPTH : count_now;
        found    = 1'b0;
        settled  = 1'b0;
        pick     = 0;
        case (b.kind)
            stot_pkg::KIND_LOAD: begin
                if (b.entry_index < TABLE_DEPTH)
                    section_image[b.entry_index] = {b.entry_virt_start, b.entry_virt_size,
                                                    b.entry_file_start, b.entry_file_size};
                r.status = stot_pkg::ST_LOADED;
            end
            stot_pkg::KIND_F2V: begin
                // file peak over the live entries, ends wrap at 32 bits
                peak = '0;
                for (j = 0; j < live; j++) begin
                    fend = section_image[j].fstart + section_image[j].fsize;
                    if (fend > peak)
                        peak = fend;
                end
                if (q < peak && q < header_now) begin
                    r.status        = stot_pkg::ST_HEADER;
                    r.mapped_offset = q;
                    r.block_size    = align_now - q;
                end else if (q < peak) begin
                    for (j = 0; j < live && !found; j++) begin
                        e    = section_image[j];
                        fend = e.fstart + e.fsize;
                        if (e.fsize != 0 && e.fstart <= q && fend > q) begin
                            found  = 1'b1;
                            off    = q - e.fstart;
                            mapped = off + e.vstart;
                            mask   = align_now - 1;
                            asz    = (e.vsize + mask) & ~mask;
                            fend   = e.vstart + asz;
                            if (!(mapped > fend)) begin
                                r.status        = stot_pkg::ST_SECTION;
                                r.mapped_offset = mapped;
                                r.block_size    = asz - off;
                                r.hit_section   = j[3:0];
                            end
                        end
                    end
                end
            end
            stot_pkg::KIND_V2F: begin
                if (q < align_now) begin
                    if (q < header_now) begin
                        r.status        = stot_pkg::ST_HEADER;
                        r.mapped_offset = q;
                        r.block_size    = header_now - q;
                    end
                end else begin
                    // first hit with file data wins, else the last zero-size hit
                    for (j = 0; j < live && !settled; j++) begin
                        e    = section_image[j];
                        fend = e.vstart + e.vsize;
                        if (e.vstart <= q && fend > q) begin
                            found = 1'b1;
                            pick  = j;
                            if (e.fsize != 0)
                                settled = 1'b1;
                        end
                    end
                    if (found) begin
                        e      = section_image[pick];
                        mapped = (q - e.vstart) + e.fstart;
                        fend   = e.fstart + e.fsize;
                        if (mapped < fend) begin
                            r.status        = stot_pkg::ST_SECTION;
                            r.mapped_offset = mapped;
                            r.block_size    = fend - mapped;
                            r.hit_section   = pick[3:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Query beat; the unused load fields carry noise.
    function automatic stot_pkg::in_beat_t query_beat(logic [1:0] kind, logic [31:0] q);
        stot_pkg::in_beat_t b;
        logic [191:0]       noise;
        noise          = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        b              = noise[$bits(stot_pkg::in_beat_t)-1:0];
        b.kind         = kind;
        b.query_offset = q;
        return b;
    endfunction

    function automatic stot_pkg::in_beat_t load_beat(logic [3:0] idx, image_section_t e);
        stot_pkg::in_beat_t b;
        logic [191:0]       noise;
        noise              = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        b                  = noise[$bits(stot_pkg::in_beat_t)-1:0];
        b.kind             = stot_pkg::KIND_LOAD;
        b.entry_index      = idx;
        b.entry_virt_start = e.vstart;
        b.entry_virt_size  = e.vsize;
        b.entry_file_start = e.fstart;
        b.entry_file_size  = e.fsize;
        return b;
    endfunction

    // Register write; only called with the block idle, so the local copy
    // can follow straight away.
    task automatic write_reg(logic [stot_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            stot_pkg::CFG_VIRT_ALIGN:    align_now  = val;
            stot_pkg::CFG_HDR_LEN:       header_now = val;
            stot_pkg::CFG_SECTION_COUNT: count_now  = val[4:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Everything sent and answered, then let the datapath settle.
    task automatic wait_drained();
        while (beat_backlog.size() != 0 || s_valid || awaited_answers.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Driver: predicts on every accepted beat, then offers the next one
    // after a random gap. Valid holds until the beat is taken.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                awaited_answers.push_back(translate_beat(s_data));
            if ($urandom_range(0, 99) == 0)
                tx_calm = !tx_calm;
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (beat_backlog.size() != 0) begin
                    s_data   <= beat_backlog.pop_front();
                    s_valid  <= 1'b1;
                    send_gap <= pick_gap(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result beat with the oldest prediction and
    // drives m_ready, including one long hold-off so the block backs up.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        stot_pkg::out_beat_t want;
        int                  g;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                answers_seen++;
                if (awaited_answers.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("result %0d arrived with nothing expected", answers_seen);
                end else begin
                    want = awaited_answers.pop_front();
                    if (m_data.status !== want.status ||
                        m_data.mapped_offset !== want.mapped_offset ||
                        m_data.block_size !== want.block_size ||
                        m_data.hit_section !== want.hit_section) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display("result %0d: exp st=%0d map=%h blk=%h sec=%0d, %s",
                                     answers_seen, want.status, want.mapped_offset,
                                     want.block_size, want.hit_section,
                                     $sformatf("got st=%0d map=%h blk=%h sec=%0d",
                                               m_data.status, m_data.mapped_offset,
                                               m_data.block_size, m_data.hit_section));
                    end
                end
            end
            if ($urandom_range(0, 99) == 0)
                rx_calm = !rx_calm;
            if (answers_seen >= LONG_HOLD_AT && !long_hold_done) begin
                // sender keeps offering meanwhile; input must stall
                long_hold_done = 1'b1;
                m_ready   <= 1'b0;
                hold_left <= LONG_HOLD_CYCLES;
            end else if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else begin
                g = pick_gap(rx_calm);
                m_ready   <= (g == 0);
                hold_left <= (g == 0) ? 0 : g - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        image_section_t layout [TABLE_DEPTH];
        image_section_t e;
        logic [31:0]    fpos, vpos, mask, span, base, q;
        logic [31:0]    phase_align, phase_header;
        logic [4:0]     phase_count;
        logic [1:0]     kind;
        int             p, i, j, sel;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset config: align 4096, header 1024, no live sections.
        beat_backlog.push_back(query_beat(stot_pkg::KIND_F2V, 32'h0));          // peak 0: out
        beat_backlog.push_back(query_beat(stot_pkg::KIND_V2F, 32'h0));          // header
        beat_backlog.push_back(query_beat(stot_pkg::KIND_V2F, 32'h3FF));        // last header byte
        beat_backlog.push_back(query_beat(stot_pkg::KIND_V2F, 32'h400));        // past header
        beat_backlog.push_back(query_beat(stot_pkg::KIND_V2F, 32'hFFFF_FFFF));  // no sections
        beat_backlog.push_back({KIND_UNUSED, {164{1'b1}}});                     // unused kind
        // small image: .text, a .bss, .data sharing its start, a file-heavy
        // section and a zero-size one whose file start wraps
        beat_backlog.push_back(load_beat(4'd0, {32'h1000, 32'h1800, 32'h400, 32'h1400}));
        beat_backlog.push_back(load_beat(4'd1, {32'h3000, 32'h800, 32'h0, 32'h0}));
        beat_backlog.push_back(load_beat(4'd2, {32'h3000, 32'h400, 32'h1800, 32'h800}));
        beat_backlog.push_back(load_beat(4'd3, {32'h5000, 32'h100, 32'h2000, 32'h3000}));
        beat_backlog.push_back(load_beat(4'd4, {32'h3400, 32'h400, 32'hFFFF_FF00, 32'h0}));
        beat_backlog.push_back(load_beat(4'd15, {128{1'b1}}));
        beat_backlog.push_back(load_beat(4'd15, 128'h0));
        wait_drained();
        write_reg(stot_pkg::CFG_SECTION_COUNT, 32'd5);
        beat_backlog.push_back(query_beat(stot_pkg::KIND_F2V, 32'h10));         // header
        beat_backlog.push_back(query_beat(stot_pkg::KIND_F2V, 32'h500));        // inside .text
        beat_backlog.push_back(query_beat(stot_pkg::KIND_F2V, 32'h4800));       // beyond aligned
        beat_backlog.push_back(query_beat(stot_pkg::KIND_F2V, 32'h1900));       // .data
        beat_backlog.push_back(query_beat(stot_pkg::KIND_F2V, 32'hFFFF_FF00));  // at the peak
        beat_backlog.push_back(query_beat(stot_pkg::KIND_F2V, 32'h10000));      // no section
        beat_backlog.push_back(query_beat(stot_pkg::KIND_V2F, 32'h3100));       // file-backed
        beat_backlog.push_back(query_beat(stot_pkg::KIND_V2F, 32'h3500));       // zero-size, wraps
        beat_backlog.push_back(query_beat(stot_pkg::KIND_V2F, 32'h2500));       // past file size
        beat_backlog.push_back(query_beat(stot_pkg::KIND_V2F, 32'h1000));       // section start
        beat_backlog.push_back(query_beat(stot_pkg::KIND_V2F, 32'h800));        // past header

        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin
                    phase_align = 32'h1;          phase_header = 32'h0;
                    phase_count = 5'd16;
                end
                1: begin
                    phase_align = 32'h8000_0000;  phase_header = 32'h1000;
                    phase_count = 5'd31;
                end
                2: begin
                    phase_align = 32'h1000;       phase_header = 32'hFFFF_FFFF;
                    phase_count = 5'd0;
                end
                3: begin
                    phase_align = 32'h200;        phase_header = 32'h200;
                    phase_count = 5'd1;
                end
                4: begin
                    phase_align = 32'h1000;       phase_header = 32'h400;
                    phase_count = 5'd20;
                end
                default: begin
                    phase_align  = 32'h1 << $urandom_range(0, 16);
                    phase_header = ($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(0, 'h1000);
                    phase_count  = 5'($urandom_range(0, 16));
                end
            endcase
            write_reg(stot_pkg::CFG_VIRT_ALIGN, phase_align);
            write_reg(stot_pkg::CFG_HDR_LEN, phase_header);
            write_reg(stot_pkg::CFG_SECTION_COUNT, {27'h0, phase_count});

            // Fresh, mostly well-formed image: the whole table is loaded
            // before any query, so no scan ever meets an unwritten entry.
            mask = align_now - 1;
            fpos = $urandom_range(0, 'h800);
            vpos = align_now;
            for (i = 0; i < TABLE_DEPTH; i++) begin
                e.fstart = fpos;
                e.fsize  = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom_range(1, 'h3000);
                e.vstart = vpos;
                e.vsize  = $urandom_range(0, 'h3000);
                if (i > 0 && $urandom_range(0, 7) == 0)
                    e.vstart = layout[i-1].vstart;
                fpos = fpos + e.fsize + $urandom_range(0, 2) * 'h100;
                vpos = vpos + ((e.vsize + mask) & ~mask) + $urandom_range(0, 1) * align_now;
                if ($urandom_range(0, 11) == 0)
                    e = {$urandom, $urandom, $urandom, $urandom};
                layout[i] = e;
                beat_backlog.push_back(load_beat(i[3:0], e));
            end

            for (i = 0; i < PHASE_BEATS; i++) begin
                sel = $urandom_range(0, 99);
                j   = $urandom_range(0, TABLE_DEPTH - 1);
                if (sel < 6) begin
                    // rewrite an entry: tweak its file size or scramble it
                    e = layout[j];
                    if ($urandom_range(0, 1))
                        e.fsize = $urandom_range(0, 1) ? 32'h0 : $urandom;
                    else
                        e = {$urandom, $urandom, $urandom, $urandom};
                    layout[j] = e;
                    beat_backlog.push_back(load_beat(j[3:0], e));
                end else if (sel < 9) begin
                    beat_backlog.push_back(query_beat(KIND_UNUSED, $urandom));
                end else begin
                    kind = $urandom_range(0, 1) ? stot_pkg::KIND_F2V : stot_pkg::KIND_V2F;
                    if (sel < 75) begin
                        // aim at a section edge or body in the space being translated
                        if (kind == stot_pkg::KIND_F2V) begin
                            base = layout[j].fstart;
                            span = layout[j].fsize;
                        end else begin
                            base = layout[j].vstart;
                            span = layout[j].vsize;
                        end
                        case ($urandom_range(0, 4))
                            0: q = base - 1;
                            1: q = base + span;
                            2: q = base + span - 1;
                            default: q = base + ((span == 0) ? 32'h0
                                                             : $urandom_range(0, span - 1));
                        endcase
                        if ($urandom_range(0, 9) == 0)
                            kind = (kind == stot_pkg::KIND_F2V) ? stot_pkg::KIND_V2F
                                                                : stot_pkg::KIND_F2V;
                    end else if (sel < 90) begin
                        base = $urandom_range(0, 1) ? header_now : align_now;
                        q    = base + $urandom_range(0, 2) - 1;
                    end else begin
                        q = $urandom;
                    end
                    beat_backlog.push_back(query_beat(kind, q));
                end
            end
        end

        wait_drained();
        if (fault_count == 0 && awaited_answers.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #(CLK_PERIOD * 1_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* section_table_offset_translator.f */
rtl/stot_pkg.sv
rtl/stot_ram.sv
rtl/stot_ctrl.sv
rtl/stot_dp.sv
rtl/section_table_offset_translator.sv
verif/section_table_offset_translator_test.sv
